/* design/pcm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the palette expand and value colormap block.
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int COLOR_W = 32;

	// item modes
	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_EXPAND = 2'd2,
		MODE_MAP    = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_BELOW = 2'd1,
		STAT_ABOVE = 2'd2,
		STAT_ERR   = 2'd3
	} stat_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_LOW  = 3'd0,
		REG_RANGE_HIGH = 3'd1,
		REG_TARGET     = 3'd2,
		REG_BLEND      = 3'd3,
		REG_USE_LIMIT  = 3'd4,
		REG_BELOW      = 3'd5,
		REG_ABOVE      = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_MAP_DIV,
		S_MAP_WAIT,
		S_MAP_RD,
		S_EXP_DIV,
		S_EXP_LAST,
		S_EXP_RDA,
		S_EXP_GETA,
		S_EXP_MUL,
		S_EXP_CDIV,
		S_EXP_CWAIT,
		S_EXP_WRL,
		S_EXP_WRA
	} state_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_LAST,
		RD_SEG,
		RD_IDX
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_APP,
		WR_LAST,
		WR_LERP,
		WR_SEG
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_CLR,
		CNT_TOTAL
	} cnt_op_t;

	typedef enum logic [1:0] {
		DIV_SPAN,
		DIV_MAP,
		DIV_LERP
	} div_sel_t;

	typedef enum logic [1:0] {
		COL_ZERO,
		COL_RAM,
		COL_BELOW,
		COL_ABOVE
	} col_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     we;
		wr_sel_t  wr_sel;
		logic     re;
		rd_sel_t  rd_sel;
		cnt_op_t  cnt_op;
		logic     div_go;
		div_sel_t div_sel;
		logic     exp_set;
		logic     b_load;
		logic     get_a;
		logic     lerp_mul;
		logic     lerp_take;
		logic     j_dec;
		logic     seg_step;
		logic     map_mul;
		logic     emit;
		stat_t    stat;
		col_sel_t col_sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  full;
		logic  n_le1;
		logic  t_lt_n;
		logic  map_bad;
		logic  below;
		logic  above;
		logic  use_limit;
		logic  div_done;
		logic  s_zero;
		logic  last_chan;
		logic  j_one;
		logic  i_zero;
	} sts_t;

endpackage

/* design/pcm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pcm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/pcm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcm_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   shift_rem;
	logic [DEN_W:0]   trial;
	logic             fits;

	// one shift and trial subtract
	always_comb begin
		shift_rem = {rem_q, quot_q[NUM_W-1]};
		fits      = shift_rem >= {1'b0, den_q};
		trial     = shift_rem - {1'b0, den_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient and remainder
	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (run_q) begin
			quot_q <= {quot_q[NUM_W-2:0], fits};
			rem_q  <= fits ? trial[DEN_W-1:0] : shift_rem[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* design/pcm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_dp
// Datapath: configuration registers, palette memory, shared divider and the
// arithmetic of palette expansion and value mapping.
// ----------------------------------------------------------------------------
module pcm_dp #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pcm_pkg::cmd_t                        cmd,
	output pcm_pkg::sts_t                        sts,
	input  logic [1:0]                           mode,
	input  logic [pcm_pkg::COLOR_W-1:0]          entry_color,
	input  logic signed [31:0]                   sample_value,
	input  logic                                 cfg_wen,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [pcm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic [pcm_pkg::COLOR_W-1:0]          color_out,
	output logic [$clog2(PALETTE_DEPTH+1)-1:0]   entry_total,
	output logic [1:0]                           status
);

	import pcm_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(PALETTE_DEPTH + 1);
	localparam int NW = 32 + AW;
	localparam int TW = (CW > 9) ? CW : 9;

	// configuration registers
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;
	logic [8:0]         target_q;
	logic               blend_q;
	logic               limit_q;
	logic [31:0]        below_q;
	logic [31:0]        above_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= '0;
			hi_q     <= 32'sd65536;
			target_q <= '0;
			blend_q  <= 1'b0;
			limit_q  <= 1'b0;
			below_q  <= '0;
			above_q  <= '0;
		end else if (cfg_wen) begin
			case (reg_idx_t'(cfg_addr))
				REG_RANGE_LOW:  lo_q     <= cfg_wdata;
				REG_RANGE_HIGH: hi_q     <= cfg_wdata;
				REG_TARGET:     target_q <= cfg_wdata[8:0];
				REG_BLEND:      blend_q  <= cfg_wdata[0];
				REG_USE_LIMIT:  limit_q  <= cfg_wdata[0];
				REG_BELOW:      below_q  <= cfg_wdata;
				REG_ABOVE:      above_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// item registers
	mode_t              mode_q;
	logic [31:0]        entry_q;
	logic signed [31:0] sample_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode_t'(mode);
			entry_q  <= entry_color;
			sample_q <= sample_value;
		end
	end

	// working registers
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] total_q;
	logic [AW-1:0] s_q;
	logic [AW-1:0] span_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] base_q;
	logic [1:0]    chan_q;
	logic [31:0]   a_q;
	logic [31:0]   b_q;
	logic [31:0]   col_q;
	logic [NW-1:0] num_s1;

	// divider
	logic [NW-1:0] div_num;
	logic [31:0]   div_den;
	logic          div_done;
	logic [NW-1:0] div_quot;
	logic [31:0]   div_rem;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	// derived values
	logic [CW-1:0]     n_m1;
	logic [TW-1:0]     tgt_ext;
	logic [TW-1:0]     tgt_sat;
	logic [CW-1:0]     tgt_c;
	logic [31:0]       v_off;
	logic [31:0]       range_w;
	logic [AW+8:0]     lerp_num;
	logic [7:0]        a_ch;
	logic [7:0]        b_ch;
	logic [32:0]       two_rem;
	logic              round_up;
	logic [NW:0]       q_rnd;
	logic [AW-1:0]     map_idx;
	logic [2*AW-1:0]   ins_prod;

	always_comb begin
		n_m1     = count_q - 1'b1;
		tgt_ext  = TW'(target_q);
		tgt_sat  = (tgt_ext > TW'(PALETTE_DEPTH)) ? TW'(PALETTE_DEPTH) : tgt_ext;
		tgt_c    = CW'(tgt_sat);
		v_off    = 32'(sample_q - lo_q);
		range_w  = 32'(hi_q - lo_q);
		a_ch     = a_q[{chan_q, 3'b000} +: 8];
		b_ch     = b_q[{chan_q, 3'b000} +: 8];
		lerp_num = (AW+9)'(j_q) * (AW+9)'(b_ch)
			+ (AW+9)'(span_q - j_q) * (AW+9)'(a_ch);
		ins_prod = div_quot[AW-1:0] * n_m1[AW-1:0];
		// round half to even, then clamp to the last entry
		two_rem  = {div_rem, 1'b0};
		round_up = (two_rem > {1'b0, range_w})
			|| ((two_rem == {1'b0, range_w}) && div_quot[0]);
		q_rnd    = {1'b0, div_quot} + (NW+1)'(round_up);
		map_idx  = (q_rnd > (NW+1)'(n_m1)) ? n_m1[AW-1:0] : q_rnd[AW-1:0];
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_SPAN: begin
				div_num = NW'(tgt_c - count_q);
				div_den = 32'(n_m1);
			end
			DIV_MAP: begin
				div_num = num_s1;
				div_den = range_w;
			end
			DIV_LERP: begin
				div_num = num_s1;
				div_den = 32'(span_q);
			end
			default: begin
				div_num = num_s1;
				div_den = 32'(span_q);
			end
		endcase
	end

	pcm_div #(
		.NUM_W(NW),
		.DEN_W(32)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// memory address and data select
	always_comb begin
		ram_we = cmd.we;
		case (cmd.wr_sel)
			WR_APP: begin
				ram_waddr = count_q[AW-1:0];
				ram_wdata = entry_q;
			end
			WR_LAST: begin
				ram_waddr = AW'(total_q - 1'b1);
				ram_wdata = ram_rdata;
			end
			WR_LERP: begin
				ram_waddr = base_q + j_q;
				ram_wdata = {col_q[31:8], blend_q ? col_q[7:0] : 8'hFF};
			end
			WR_SEG: begin
				ram_waddr = base_q;
				ram_wdata = a_q;
			end
			default: begin
				ram_waddr = base_q;
				ram_wdata = a_q;
			end
		endcase
		case (cmd.rd_sel)
			RD_FIRST: ram_raddr = '0;
			RD_LAST:  ram_raddr = n_m1[AW-1:0];
			RD_SEG:   ram_raddr = i_q;
			RD_IDX:   ram_raddr = map_idx;
			default:  ram_raddr = '0;
		endcase
	end

	pcm_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// entry count
	always_comb begin
		case (cmd.cnt_op)
			CNT_HOLD:  count_d = count_q;
			CNT_INC:   count_d = count_q + 1'b1;
			CNT_CLR:   count_d = '0;
			CNT_TOTAL: count_d = total_q;
			default:   count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// expansion and mapping working registers
	always_ff @(posedge clk) begin
		if (cmd.exp_set) begin
			s_q     <= div_quot[AW-1:0];
			span_q  <= div_quot[AW-1:0] + 1'b1;
			total_q <= count_q + CW'(ins_prod);
			i_q     <= AW'(count_q - CW'(2));
		end
		if (cmd.b_load) begin
			b_q <= ram_rdata;
		end
		if (cmd.get_a) begin
			a_q    <= ram_rdata;
			j_q    <= s_q;
			base_q <= AW'(i_q * span_q);
			chan_q <= 2'd3;
		end
		if (cmd.lerp_mul) begin
			num_s1 <= NW'(lerp_num);
		end
		if (cmd.map_mul) begin
			num_s1 <= NW'(v_off) * NW'(n_m1[AW-1:0]);
		end
		if (cmd.lerp_take) begin
			col_q[{chan_q, 3'b000} +: 8] <= div_quot[7:0];
			chan_q <= chan_q - 1'b1;
		end
		if (cmd.j_dec) begin
			j_q    <= j_q - 1'b1;
			chan_q <= 2'd3;
		end
		if (cmd.seg_step) begin
			b_q <= a_q;
			i_q <= i_q - 1'b1;
		end
	end

	// result registers
	logic [31:0]   color_q;
	logic [CW-1:0] total_out_q;
	stat_t         stat_q;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			stat_q      <= cmd.stat;
			total_out_q <= count_d;
			case (cmd.col_sel)
				COL_ZERO:  color_q <= '0;
				COL_RAM:   color_q <= ram_rdata;
				COL_BELOW: color_q <= below_q;
				COL_ABOVE: color_q <= above_q;
				default:   color_q <= '0;
			endcase
		end
	end

	assign color_out   = color_q;
	assign entry_total = total_out_q;
	assign status      = stat_q;

	// status toward the controller
	always_comb begin
		sts.mode      = mode_q;
		sts.full      = count_q >= CW'(PALETTE_DEPTH);
		sts.n_le1     = count_q <= CW'(1);
		sts.t_lt_n    = tgt_c < count_q;
		sts.map_bad   = (count_q == '0) || (hi_q <= lo_q);
		sts.below     = sample_q < lo_q;
		sts.above     = sample_q > hi_q;
		sts.use_limit = limit_q;
		sts.div_done  = div_done;
		sts.s_zero    = s_q == '0;
		sts.last_chan = (chan_q == 2'd0) || ((chan_q == 2'd1) && !blend_q);
		sts.j_one     = j_q == AW'(1);
		sts.i_zero    = i_q == '0;
	end

endmodule

/* design/pcm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ctrl
// Controller: sequences append, clear, expand and map over the datapath.
// ----------------------------------------------------------------------------
module pcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	input  pcm_pkg::sts_t sts,
	output pcm_pkg::cmd_t cmd
);

	import pcm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (sts.mode)
					MODE_APPEND: begin
						cmd.emit = 1'b1;
						if (sts.full) begin
							cmd.stat = STAT_ERR;
						end else begin
							cmd.we     = 1'b1;
							cmd.wr_sel = WR_APP;
							cmd.cnt_op = CNT_INC;
						end
					end
					MODE_CLEAR: begin
						cmd.emit   = 1'b1;
						cmd.cnt_op = CNT_CLR;
					end
					MODE_EXPAND: begin
						if (sts.n_le1) begin
							cmd.emit = 1'b1;
							cmd.stat = STAT_ERR;
						end else if (sts.t_lt_n) begin
							cmd.emit = 1'b1;
						end else begin
							cmd.div_go  = 1'b1;
							cmd.div_sel = DIV_SPAN;
							state_d     = S_EXP_DIV;
						end
					end
					MODE_MAP: begin
						if (sts.map_bad) begin
							cmd.emit = 1'b1;
							cmd.stat = STAT_ERR;
						end else if (sts.below) begin
							if (sts.use_limit) begin
								cmd.emit    = 1'b1;
								cmd.stat    = STAT_BELOW;
								cmd.col_sel = COL_BELOW;
							end else begin
								cmd.re     = 1'b1;
								cmd.rd_sel = RD_FIRST;
								state_d    = S_MAP_RD;
							end
						end else if (sts.above) begin
							if (sts.use_limit) begin
								cmd.emit    = 1'b1;
								cmd.stat    = STAT_ABOVE;
								cmd.col_sel = COL_ABOVE;
							end else begin
								cmd.re     = 1'b1;
								cmd.rd_sel = RD_LAST;
								state_d    = S_MAP_RD;
							end
						end else begin
							cmd.map_mul = 1'b1;
							state_d     = S_MAP_DIV;
						end
					end
					default: ;
				endcase
			end
			S_MAP_DIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_MAP;
				state_d     = S_MAP_WAIT;
			end
			S_MAP_WAIT: begin
				cmd.div_sel = DIV_MAP;
				if (sts.div_done) begin
					cmd.re     = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_MAP_RD;
				end
			end
			S_MAP_RD: begin
				cmd.emit    = 1'b1;
				cmd.col_sel = COL_RAM;
				if (sts.below) begin
					cmd.stat = STAT_BELOW;
				end else if (sts.above) begin
					cmd.stat = STAT_ABOVE;
				end
				state_d = S_IDLE;
			end
			S_EXP_DIV: begin
				if (sts.div_done) begin
					cmd.exp_set = 1'b1;
					cmd.re      = 1'b1;
					cmd.rd_sel  = RD_LAST;
					state_d     = S_EXP_LAST;
				end
			end
			S_EXP_LAST: begin
				cmd.we     = 1'b1;
				cmd.wr_sel = WR_LAST;
				cmd.b_load = 1'b1;
				state_d    = S_EXP_RDA;
			end
			S_EXP_RDA: begin
				cmd.re     = 1'b1;
				cmd.rd_sel = RD_SEG;
				state_d    = S_EXP_GETA;
			end
			S_EXP_GETA: begin
				cmd.get_a = 1'b1;
				state_d   = sts.s_zero ? S_EXP_WRA : S_EXP_MUL;
			end
			S_EXP_MUL: begin
				cmd.lerp_mul = 1'b1;
				state_d      = S_EXP_CDIV;
			end
			S_EXP_CDIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_LERP;
				state_d     = S_EXP_CWAIT;
			end
			S_EXP_CWAIT: begin
				cmd.div_sel = DIV_LERP;
				if (sts.div_done) begin
					cmd.lerp_take = 1'b1;
					state_d       = sts.last_chan ? S_EXP_WRL : S_EXP_MUL;
				end
			end
			S_EXP_WRL: begin
				cmd.we     = 1'b1;
				cmd.wr_sel = WR_LERP;
				cmd.j_dec  = 1'b1;
				state_d    = sts.j_one ? S_EXP_WRA : S_EXP_MUL;
			end
			S_EXP_WRA: begin
				cmd.we       = 1'b1;
				cmd.wr_sel   = WR_SEG;
				cmd.seg_step = 1'b1;
				if (sts.i_zero) begin
					cmd.cnt_op = CNT_TOTAL;
					cmd.emit   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_EXP_RDA;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/palette_expand_and_value_colormap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_expand_and_value_colormap
// RGBA palette with append, clear, linear expansion and value to color map.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers when start is high and busy is low. Exactly one result
//   follows: done is high for one cycle with color_out, entry_total and
//   status valid; the receiver must take it then, it cannot stall the block.
//   One item is in work at a time; busy stays high until the result cycle.
//   Map and expand use the shared restoring divider, one quotient bit a
//   cycle, whose numerator is NW = 32 + log2(PALETTE_DEPTH) bits wide (40 at
//   depth 256). Expand writes through the single write port of the palette
//   memory and interpolates 3 channels per inserted color, 4 with alpha blend.
//   Configuration is written through cfg_wen/cfg_addr/cfg_wdata; the user
//   must write it only while idle, the block itself does not enforce this.
//   Reset empties the palette and loads default registers; palette memory
//   content is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module palette_expand_and_value_colormap #(
	parameter int PALETTE_DEPTH = pcm_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         mode,
	input  logic [pcm_pkg::COLOR_W-1:0]        entry_color,
	input  logic signed [31:0]                 sample_value,
	input  logic                               cfg_wen,
	input  logic [pcm_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [pcm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                               done,
	output logic [pcm_pkg::COLOR_W-1:0]        color_out,
	output logic [$clog2(PALETTE_DEPTH+1)-1:0] entry_total,
	output logic [1:0]                         status
);

	import pcm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	pcm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.sts   (sts),
		.cmd   (cmd)
	);

	// arithmetic, registers and palette memory
	pcm_dp #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.entry_color (entry_color),
		.sample_value(sample_value),
		.cfg_wen     (cfg_wen),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.color_out   (color_out),
		.entry_total (entry_total),
		.status      (status)
	);

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the palette expand and value colormap block.
// A behavioral palette model predicts the result of every item sent. A
// directed pass covers the error cases, the range ends, saturation of the
// expansion target and alpha blending. Random phases then follow, each with
// its own register setting. Every done cycle is checked against the oldest
// pending prediction.
// ----------------------------------------------------------------------------
module testbench;
	import pcm_pkg::*;

	localparam int DEPTH = 256;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam longint CYCLE_LIMIT = 20000000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           mode;
	logic [31:0]          entry_color;
	logic signed [31:0]   sample_value;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [31:0]          cfg_wdata;
	logic                 done;
	logic [31:0]          color_out;
	logic [CNT_W-1:0]     entry_total;
	logic [1:0]           status;

	palette_expand_and_value_colormap #(.PALETTE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.entry_color(entry_color), .sample_value(sample_value),
		.cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.done(done), .color_out(color_out), .entry_total(entry_total),
		.status(status)
	);

	// expected result of one item
	typedef struct {
		logic [31:0]      color;
		logic [CNT_W-1:0] total;
		stat_t            stat;
	} pcm_result_t;

	pcm_result_t pending_results[$];
	int          error_count;
	longint      cycle_count;
	int          burst_left;

	// palette model state
	logic [31:0]        pal_mem[DEPTH];
	int                 pal_count;
	logic signed [31:0] m_range_low;
	logic signed [31:0] m_range_high;
	int                 m_target;
	logic               m_blend;
	logic               m_use_limit;
	logic [31:0]        m_below;
	logic [31:0]        m_above;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		pcm_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no pending prediction");
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (color_out !== exp_r.color) begin
					$error("color_out expected %h actual %h", exp_r.color, color_out);
					error_count++;
				end
				if (entry_total !== exp_r.total) begin
					$error("entry_total expected %0d actual %0d", exp_r.total, entry_total);
					error_count++;
				end
				if (status !== exp_r.stat) begin
					$error("status expected %0d actual %0d", exp_r.stat, status);
					error_count++;
				end
			end
		end
	end

	// one interpolated channel
	function automatic int lerp_chan(int a, int b, int j, int span);
		return (j * b + (span - j) * a) / span;
	endfunction

	// expansion of the model palette
	function automatic stat_t model_expand();
		logic [31:0] scr[DEPTH];
		logic [31:0] ca;
		logic [31:0] cb;
		logic [31:0] c;
		int t;
		int s;
		int span;
		int total;
		if (pal_count <= 1)
			return STAT_ERR;
		t = (m_target > DEPTH) ? DEPTH : m_target;
		if (t < pal_count)
			return STAT_OK;
		s = (t - pal_count) / (pal_count - 1);
		span = s + 1;
		total = pal_count + s * (pal_count - 1);
		for (int i = 0; i + 1 < pal_count; i++) begin
			ca = pal_mem[i];
			cb = pal_mem[i + 1];
			scr[i * span] = ca;
			for (int j = 1; j <= s; j++) begin
				for (int sh = 8; sh <= 24; sh += 8)
					c[sh +: 8] = 8'(lerp_chan(ca[sh +: 8], cb[sh +: 8], j, span));
				c[7:0] = m_blend ? 8'(lerp_chan(ca[7:0], cb[7:0], j, span)) : 8'hff;
				scr[i * span + j] = c;
			end
		end
		scr[total - 1] = pal_mem[pal_count - 1];
		for (int i = 0; i < total; i++)
			pal_mem[i] = scr[i];
		pal_count = total;
		return STAT_OK;
	endfunction

	// mapping of one sample
	function automatic stat_t model_map(logic signed [31:0] smp, output logic [31:0] col);
		longint v;
		longint lo;
		longint hi;
		longint num;
		longint den;
		longint q;
		longint r;
		v = smp;
		lo = m_range_low;
		hi = m_range_high;
		col = '0;
		if (pal_count == 0 || hi <= lo)
			return STAT_ERR;
		if (v < lo) begin
			col = m_use_limit ? m_below : pal_mem[0];
			return STAT_BELOW;
		end
		if (v > hi) begin
			col = m_use_limit ? m_above : pal_mem[pal_count - 1];
			return STAT_ABOVE;
		end
		num = (v - lo) * (pal_count - 1);
		den = hi - lo;
		q = num / den;
		r = num % den;
		if (2 * r > den || (2 * r == den && q[0]))
			q++;
		if (q > pal_count - 1)
			q = pal_count - 1;
		col = pal_mem[q];
		return STAT_OK;
	endfunction

	// predicted result of one accepted item
	function automatic pcm_result_t palette_predict(mode_t md, logic [31:0] ent,
			logic signed [31:0] smp);
		pcm_result_t res;
		res.color = '0;
		res.stat = STAT_OK;
		case (md)
			MODE_APPEND: begin
				if (pal_count >= DEPTH)
					res.stat = STAT_ERR;
				else begin
					pal_mem[pal_count] = ent;
					pal_count++;
				end
			end
			MODE_CLEAR: pal_count = 0;
			MODE_EXPAND: res.stat = model_expand();
			default: res.stat = model_map(smp, res.color);
		endcase
		res.total = CNT_W'(pal_count);
		return res;
	endfunction

	// one item transfer, with bursty sender gaps
	task automatic send_item(mode_t md, logic [31:0] ent, logic signed [31:0] smp);
		pcm_result_t pred;
		@(negedge clk);
		start = 1'b1;
		mode = md;
		entry_color = ent;
		sample_value = smp;
		do @(posedge clk); while (busy);
		pred = palette_predict(md, ent, smp);
		pending_results = {pending_results, pred};
		if (burst_left > 0)
			burst_left--;
		else begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, only while idle
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		wait_idle();
		cfg_wen = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_RANGE_LOW:  m_range_low = val;
			REG_RANGE_HIGH: m_range_high = val;
			REG_TARGET:     m_target = val[8:0];
			REG_BLEND:      m_blend = val[0];
			REG_USE_LIMIT:  m_use_limit = val[0];
			REG_BELOW:      m_below = val;
			REG_ABOVE:      m_above = val;
			default: ;
		endcase
	endtask

	task automatic send_map(logic signed [31:0] smp);
		send_item(MODE_MAP, $urandom, smp);
	endtask

	task automatic send_append(logic [31:0] ent);
		send_item(MODE_APPEND, ent, $urandom);
	endtask

	// directed cases: errors, range ends, limits, saturation, alpha blend
	task automatic test_directed();
		send_map(32'sd100);
		send_item(MODE_EXPAND, 32'h0, 32'sh0);
		send_append(32'h0000_0000);
		send_item(MODE_EXPAND, 32'h0, 32'sh0);
		send_append(32'hffff_ffff);
		send_append(32'h80ff_1040);
		send_map(32'sd0);
		send_map(32'sd65536);
		send_map(32'sd32768);
		send_map(-32'sd1);
		send_map(32'sd65537);
		write_reg(REG_BELOW, 32'h1122_3344);
		write_reg(REG_ABOVE, 32'hccdd_eeff);
		write_reg(REG_USE_LIMIT, 32'h1);
		send_map(32'sh8000_0000);
		send_map(32'sh7fff_ffff);
		write_reg(REG_TARGET, 32'd2);
		send_item(MODE_EXPAND, 32'h0, 32'sh0);
		write_reg(REG_TARGET, 32'd9);
		write_reg(REG_BLEND, 32'h1);
		send_item(MODE_EXPAND, 32'h0, 32'sh0);
		write_reg(REG_RANGE_HIGH, 32'sh0);
		send_map(32'sh0);
		write_reg(REG_RANGE_LOW, 32'sh8000_0000);
		write_reg(REG_RANGE_HIGH, 32'sh7fff_ffff);
		send_map(32'sh0);
		send_map(32'sh8000_0000);
		send_map(32'sh7fff_ffff);
		// target past depth saturates to the palette depth
		write_reg(REG_BLEND, 32'h0);
		write_reg(REG_TARGET, 32'd511);
		send_item(MODE_EXPAND, 32'h0, 32'sh0);
		send_append(32'h0102_0304);
		send_map(32'sh1234_5678);
		send_item(MODE_CLEAR, 32'h0, 32'sh0);
		send_map(32'sh0);
	endtask

	// random phases with well-formed palette build and mixed traffic
	task automatic test_random(int n_items);
		int sent;
		int sel;
		int lo;
		int span;
		sent = 0;
		while (sent < n_items) begin
			// new setting for this phase
			sel = $urandom_range(0, 3);
			case (sel)
				0: begin
					lo = -32'sd65536;
					span = 32'sd196608;
				end
				1: begin
					lo = $urandom;
					span = $urandom_range(1, 1000);
				end
				2: begin
					lo = 32'sh8000_0000;
					span = 32'sh7fff_ffff;
				end
				default: begin
					lo = $urandom;
					span = $urandom;
				end
			endcase
			write_reg(REG_RANGE_LOW, lo);
			write_reg(REG_RANGE_HIGH, ($urandom_range(0, 9) == 0) ? $urandom : lo + span);
			write_reg(REG_TARGET, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
				: $urandom_range(0, 40));
			write_reg(REG_BLEND, $urandom_range(0, 1));
			write_reg(REG_USE_LIMIT, $urandom_range(0, 1));
			write_reg(REG_BELOW, $urandom);
			write_reg(REG_ABOVE, $urandom);
			send_item(MODE_CLEAR, $urandom, $urandom);
			repeat ($urandom_range(1, 8)) send_append($urandom);
			send_item(MODE_EXPAND, $urandom, $urandom);
			sent += 3;
			repeat ($urandom_range(40, 80)) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					if ($urandom_range(0, 4) == 0)
						send_map($urandom);
					else if ($urandom_range(0, 9) == 0)
						send_map(m_range_low + $signed($urandom_range(0, 2)) - 1);
					else
						send_map(m_range_low + int'((longint'(m_range_high) -
							longint'(m_range_low)) * $urandom_range(0, 1000) / 1000));
				end else if (sel < 88)
					send_append($urandom);
				else if (sel < 96 && pal_count <= 40)
					send_item(MODE_EXPAND, $urandom, $urandom);
				else if (sel < 98)
					send_item(MODE_CLEAR, $urandom, $urandom);
				else
					send_map($urandom);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_APPEND;
		entry_color = '0;
		sample_value = '0;
		cfg_wen = 1'b0;
		cfg_addr = REG_RANGE_LOW;
		cfg_wdata = '0;
		error_count = 0;
		cycle_count = 0;
		burst_left = 0;
		pal_count = 0;
		m_range_low = 32'sd0;
		m_range_high = 32'sd65536;
		m_target = 0;
		m_blend = 1'b0;
		m_use_limit = 1'b0;
		m_below = '0;
		m_above = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(800);
		wait_idle();
		repeat (60) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* palette_expand_and_value_colormap.f */
design/pcm_pkg.sv
design/pcm_ram.sv
design/pcm_div.sv
design/pcm_dp.sv
design/pcm_ctrl.sv
design/palette_expand_and_value_colormap.sv
sim/testbench.sv
